/* hw/rtl/hppp_pkg.sv */
// Shared types, constants and arithmetic step functions for the hyperboloid translate block.
package hppp_pkg;

  localparam int FRAC_BITS_DEF   = 24;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SHIFT_W         = 29;
  localparam int WEIGHT_W        = 17;
  localparam int WEIGHT_FRAC     = 16;
  localparam int REG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 29;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SHIFT_X      = 3'd0,
    REG_SHIFT_Y      = 3'd1,
    REG_SHIFT_Z      = 3'd2,
    REG_BLEND_WEIGHT = 3'd3,
    REG_THREE_D_MODE = 3'd4,
    REG_PLAIN_SHIFT  = 3'd5
  } reg_index_t;

  typedef logic signed [31:0] word_t;
  typedef logic signed [SHIFT_W-1:0] shift_t;
  typedef logic [2:0][31:0] vec3_t;
  typedef logic [8:0][31:0] blk_t;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] out_first;
    logic signed [31:0] out_second;
    logic signed [31:0] out_third;
  } result_t;

  // configuration as seen by the datapath; t already has z forced to zero in 2D
  typedef struct packed {
    logic [2:0][SHIFT_W-1:0] t;
    logic                    plain;
    logic                    three_d;
    logic [WEIGHT_W-1:0]     weight;
  } cfg_view_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [32:0] rem;
    logic        q;
  } div_st_t;

  function automatic word_t sat32(logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return word_t'(v[31:0]);
  endfunction

  // one result bit of a digit-by-digit square root, two radicand bits in
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] bits);
    logic [35:0] acc;
    logic [35:0] trial;
    sqrt_st_t r;
    acc   = {s.rem, bits};
    trial = {2'b00, s.root, 2'b01};
    if (acc >= trial) begin
      r.rem  = 34'(acc - trial);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = acc[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of restoring division; rem stays below den
  function automatic div_st_t div_step(logic [32:0] rem, logic [32:0] den, logic bit_in);
    logic [33:0] acc;
    div_st_t r;
    acc = {rem, bit_in};
    if (acc >= {1'b0, den}) begin
      r.rem = 33'(acc - {1'b0, den});
      r.q   = 1'b1;
    end else begin
      r.rem = acc[32:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/hppp_fifo.sv */
// Small register queue with full/empty flags.
module hppp_fifo #(
  parameter int WIDTH = 96,
  parameter int DEPTH = hppp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

/* hw/rtl/hppp_lift.sv */
// Pipelined hyperboloid lift: sqrt(x^2 + y^2 + z^2 + 1), one result bit per stage.
module hppp_lift #(
  parameter int FRAC_BITS = hppp_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  hppp_pkg::vec3_t     in_v,
  output logic                out_vld,
  output hppp_pkg::vec3_t     out_v,
  output hppp_pkg::word_t     out_root
);
  localparam int Steps = 32;
  localparam logic [63:0] OneSq = 64'd1 << (2 * FRAC_BITS);

  logic                sq_vld;
  logic [2:0][63:0]    sq;
  hppp_pkg::vec3_t     sq_v;

  logic                vld [Steps+1];
  hppp_pkg::vec3_t     v   [Steps+1];
  logic [63:0]         val [Steps+1];
  hppp_pkg::sqrt_st_t  st  [Steps+1];

  always_ff @(posedge clk) begin
    if (rst) sq_vld <= 1'b0;
    else if (en) sq_vld <= in_vld;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= 64'($signed(in_v[i])) * 64'($signed(in_v[i]));
      end
      sq_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= sq_vld;
    if (en) begin
      val[0] <= sq[0] + sq[1] + sq[2] + OneSq;
      v[0]   <= sq_v;
      st[0]  <= '0;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_root
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
      if (en) begin
        st[k+1]  <= hppp_pkg::sqrt_step(st[k], val[k][63:62]);
        val[k+1] <= {val[k][61:0], 2'b00};
        v[k+1]   <= v[k];
      end
    end
  end

  assign out_vld  = vld[Steps];
  assign out_v    = v[Steps];
  assign out_root = st[Steps].root[31] ? 32'sh7FFF_FFFF : $signed(st[Steps].root);

endmodule

/* hw/rtl/hppp_boost.sv */
// Sequential builder of the boost matrix spatial block after shift or mode writes.
module hppp_boost #(
  parameter int FRAC_BITS = hppp_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [2:0][hppp_pkg::SHIFT_W-1:0] t,
  output logic                       busy,
  output hppp_pkg::blk_t             blk
);
  localparam int QuoW = hppp_pkg::SHIFT_W;
  localparam int ProdW = 2 * hppp_pkg::SHIFT_W;
  localparam logic [63:0] OneSq = 64'd1 << (2 * FRAC_BITS);
  localparam logic [59:0] SmallSq = 60'(OneSq / 64'd1000000);
  localparam logic [31:0] One = 32'd1 << FRAC_BITS;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SUM  = 5'b00010,
    B_ROOT = 5'b00100,
    B_MUL  = 5'b01000,
    B_DIV  = 5'b10000
  } bstate_t;

  bstate_t             state;
  logic [4:0]          step;
  logic [2:0]          pair;
  hppp_pkg::shift_t    tr [3];
  logic [59:0]         acc;
  logic                big;
  logic [63:0]         val;
  hppp_pkg::sqrt_st_t  st;
  logic [32:0]         den;
  logic [32:0]         rem;
  logic [QuoW-1:0]     dvd;
  logic [QuoW-1:0]     quo;
  logic                neg;

  logic [1:0]          row;
  logic [1:0]          col;
  logic signed [ProdW-1:0] sq;
  logic [59:0]         acc_next;
  hppp_pkg::sqrt_st_t  st_next;
  logic signed [ProdW-1:0] prod;
  logic [ProdW-1:0]    mag;
  hppp_pkg::div_st_t   ds;
  logic [QuoW-1:0]     quo_next;
  logic signed [31:0]  qs;
  logic [31:0]         entry;

  assign busy = (state != B_IDLE);

  // pairs of the symmetric 3x3 block, upper triangle
  always_comb begin
    case (pair)
      3'd0:    begin row = 2'd0; col = 2'd0; end
      3'd1:    begin row = 2'd0; col = 2'd1; end
      3'd2:    begin row = 2'd0; col = 2'd2; end
      3'd3:    begin row = 2'd1; col = 2'd1; end
      3'd4:    begin row = 2'd1; col = 2'd2; end
      3'd5:    begin row = 2'd2; col = 2'd2; end
      default: begin row = 2'd0; col = 2'd0; end
    endcase
  end

  always_comb begin
    sq       = ProdW'(tr[step[1:0]]) * ProdW'(tr[step[1:0]]);
    acc_next = acc + 60'(sq);
    st_next  = hppp_pkg::sqrt_step(st, val[63:62]);
    prod     = ProdW'(tr[row]) * ProdW'(tr[col]);
    mag      = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
    ds       = hppp_pkg::div_step(rem, den, dvd[QuoW-1]);
    quo_next = {quo[QuoW-2:0], ds.q};
    qs       = neg ? -$signed(32'(quo_next)) : $signed(32'(quo_next));
    entry    = ((row == col) ? One : 32'd0) + (big ? 32'(qs) : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
      pair  <= '0;
      for (int i = 0; i < 9; i++) begin
        blk[i] <= (i == 0 || i == 4 || i == 8) ? One : 32'd0;
      end
    end else if (start) begin
      for (int i = 0; i < 3; i++) tr[i] <= $signed(t[i]);
      acc   <= '0;
      step  <= '0;
      state <= B_SUM;
    end else begin
      case (state)
        B_IDLE: ;
        B_SUM: begin
          acc <= acc_next;
          if (step == 5'd2) begin
            big   <= (acc_next > SmallSq);
            val   <= 64'(acc_next) + OneSq;
            st    <= '0;
            step  <= '0;
            state <= B_ROOT;
          end else begin
            step <= step + 1'b1;
          end
        end
        B_ROOT: begin
          st   <= st_next;
          val  <= {val[61:0], 2'b00};
          step <= step + 1'b1;
          if (step == 5'd31) begin
            den   <= 33'(st_next.root) + 33'(One);
            pair  <= '0;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          neg   <= prod[ProdW-1];
          rem   <= 33'(mag >> QuoW);
          dvd   <= mag[QuoW-1:0];
          quo   <= '0;
          step  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          rem  <= ds.rem;
          dvd  <= {dvd[QuoW-2:0], 1'b0};
          quo  <= quo_next;
          step <= step + 1'b1;
          if (step == 5'(QuoW - 1)) begin
            blk[4'(row) * 4'd3 + 4'(col)] <= entry;
            if (row != col) blk[4'(col) * 4'd3 + 4'(row)] <= entry;
            pair  <= pair + 1'b1;
            state <= (pair == 3'd5) ? B_IDLE : B_MUL;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/hppp_front.sv */
// Front end: accepts points, lifts them and applies the shift or the boost matrix.
module hppp_front #(
  parameter int FRAC_BITS = hppp_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  hppp_pkg::vec3_t      in_v,
  input  hppp_pkg::cfg_view_t  cfg,
  input  hppp_pkg::blk_t       blk,
  input  logic                 mid_full,
  output logic                 ready,
  output logic                 mid_push,
  output hppp_pkg::vec3_t      mid_data
);
  logic               en;
  logic               l_vld;
  hppp_pkg::vec3_t    l_v;
  hppp_pkg::word_t    l_root;

  logic               a_vld;
  logic signed [63:0] prod [3][4];
  hppp_pkg::word_t    plain_y [3];
  logic               b_vld;
  logic signed [65:0] sum [3];

  assign en       = !(b_vld && mid_full);
  assign ready    = en;
  assign mid_push = b_vld && !mid_full;

  hppp_lift #(.FRAC_BITS(FRAC_BITS)) u_lift (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_vld),
    .in_v    (in_v),
    .out_vld (l_vld),
    .out_v   (l_v),
    .out_root(l_root)
  );

  // column 0 of the boost matrix is -t
  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= l_vld;
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= -(64'($signed(cfg.t[r])) * 64'(l_root));
        for (int c = 0; c < 3; c++) begin
          prod[r][c+1] <= 64'($signed(blk[r*3+c])) * 64'($signed(l_v[c]));
        end
        plain_y[r] <= hppp_pkg::sat32(66'($signed(l_v[r])) - 66'($signed(cfg.t[r])));
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 66'(prod[r][0] >>> FRAC_BITS) + 66'(prod[r][1] >>> FRAC_BITS)
             + 66'(prod[r][2] >>> FRAC_BITS) + 66'(prod[r][3] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en) b_vld <= a_vld;
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        mid_data[r] <= cfg.plain ? plain_y[r] : hppp_pkg::sat32(sum[r]);
      end
    end
  end

endmodule

/* hw/rtl/hppp_back.sv */
// Back end: relifts the moved point, projects it into the ball and blends.
module hppp_back #(
  parameter int FRAC_BITS = hppp_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mid_empty,
  input  hppp_pkg::vec3_t      mid_data,
  input  hppp_pkg::cfg_view_t  cfg,
  input  logic                 out_full,
  output logic                 mid_pop,
  output logic                 out_push,
  output hppp_pkg::result_t    out_data
);
  localparam logic [32:0] One = 33'd1 << FRAC_BITS;

  logic               en;
  logic               l_vld;
  hppp_pkg::vec3_t    l_v;
  hppp_pkg::word_t    l_root;

  // divider pipeline; index 0 is the setup stage
  logic                 d_vld [FRAC_BITS+1];
  logic [32:0]          d_den [FRAC_BITS+1];
  logic [3:0][31:0]     d_y   [FRAC_BITS+1];
  logic [2:0]           d_neg [FRAC_BITS+1];
  logic [2:0][32:0]     d_rem [FRAC_BITS+1];
  logic [2:0][FRAC_BITS-1:0] d_quo [FRAC_BITS+1];

  logic signed [17:0]   w;
  logic signed [17:0]   lam;
  logic                 p_vld;
  logic signed [49:0]   wy [4];
  logic signed [49:0]   lq [3];
  logic signed [31:0]   qv [3];
  hppp_pkg::word_t      m  [4];
  logic                 o_vld;

  assign en       = !(o_vld && out_full);
  assign mid_pop  = en && !mid_empty;
  assign out_push = o_vld && !out_full;
  assign lam      = $signed({1'b0, cfg.weight});
  assign w        = $signed({1'b0, hppp_pkg::WEIGHT_ONE}) - lam;

  hppp_lift #(.FRAC_BITS(FRAC_BITS)) u_lift (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (mid_pop),
    .in_v    (mid_data),
    .out_vld (l_vld),
    .out_v   (l_v),
    .out_root(l_root)
  );

  always_ff @(posedge clk) begin
    if (rst) d_vld[0] <= 1'b0;
    else if (en) d_vld[0] <= l_vld;
    if (en) begin
      d_den[0] <= 33'($unsigned(l_root)) + One;
      d_y[0]   <= {l_v[2], l_v[1], l_v[0], l_root};
      d_quo[0] <= '0;
      for (int r = 0; r < 3; r++) begin
        d_neg[0][r] <= l_v[r][31];
        d_rem[0][r] <= l_v[r][31] ? 33'(-$signed(33'($signed(l_v[r]))))
                                  : 33'($signed(l_v[r]));
      end
    end
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    hppp_pkg::div_st_t ds [3];
    always_comb begin
      for (int r = 0; r < 3; r++) ds[r] = hppp_pkg::div_step(d_rem[k][r], d_den[k], 1'b0);
    end
    always_ff @(posedge clk) begin
      if (rst) d_vld[k+1] <= 1'b0;
      else if (en) d_vld[k+1] <= d_vld[k];
      if (en) begin
        d_den[k+1] <= d_den[k];
        d_y[k+1]   <= d_y[k];
        d_neg[k+1] <= d_neg[k];
        for (int r = 0; r < 3; r++) begin
          d_rem[k+1][r] <= ds[r].rem;
          d_quo[k+1][r] <= {d_quo[k][r][FRAC_BITS-2:0], ds[r].q};
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      qv[r] = d_neg[FRAC_BITS][r] ? -$signed(32'(d_quo[FRAC_BITS][r]))
                                  : $signed(32'(d_quo[FRAC_BITS][r]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else if (en) p_vld <= d_vld[FRAC_BITS];
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        wy[r] <= 50'(w) * 50'($signed(d_y[FRAC_BITS][r]));
      end
      for (int r = 0; r < 3; r++) begin
        lq[r] <= 50'(lam) * 50'(qv[r]);
      end
    end
  end

  // the time component has no projected part
  always_comb begin
    m[0] = hppp_pkg::sat32(66'(wy[0] >>> hppp_pkg::WEIGHT_FRAC));
    for (int r = 1; r < 4; r++) begin
      m[r] = hppp_pkg::sat32(66'((51'(wy[r]) + 51'(lq[r-1])) >>> hppp_pkg::WEIGHT_FRAC));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) o_vld <= 1'b0;
    else if (en) o_vld <= p_vld;
    if (en) begin
      out_data.out_first  <= m[1];
      out_data.out_second <= m[2];
      out_data.out_third  <= cfg.three_d ? m[3] : m[0];
    end
  end

endmodule

/* hw/rtl/hyperboloid_point_translate_project.sv */
// Throughput: one item per cycle while no queue backs up and no matrix rebuild is running;
// set by the 32-stage root pipelines and the FRAC_BITS-stage divider; the front and back
// halves each advance only while the queue after them has room.
// After a write to shift_x/y/z or three_d_mode, full stays high while the boost matrix
// is rebuilt bit-serially. Reset is synchronous: registers return to defaults, the
// matrix to identity, and both queues empty.
module hyperboloid_point_translate_project #(
  parameter int FRAC_BITS   = hppp_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = hppp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  hppp_pkg::point_t                   point,
  output logic                               full,
  output logic                               empty,
  input  logic                               pop,
  output hppp_pkg::result_t                  result,
  input  logic                               cfg_we,
  input  logic [hppp_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [hppp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  hppp_pkg::shift_t              shift_x;
  hppp_pkg::shift_t              shift_y;
  hppp_pkg::shift_t              shift_z;
  logic [hppp_pkg::WEIGHT_W-1:0] blend_weight;
  logic                          three_d_mode;
  logic                          plain_shift;
  logic                          rebuild;
  logic                          shape_write;

  hppp_pkg::cfg_view_t cfg;
  hppp_pkg::blk_t      blk;
  logic                build_busy;
  logic                front_ready;
  logic                accept;
  hppp_pkg::vec3_t     in_v;

  logic                mid_push;
  logic                mid_pop;
  logic                mid_full;
  logic                mid_empty;
  hppp_pkg::vec3_t     mid_wdata;
  hppp_pkg::vec3_t     mid_rdata;

  logic                out_push;
  logic                out_full;
  hppp_pkg::result_t   out_wdata;

  assign shape_write = cfg_we && (hppp_pkg::reg_index_t'(cfg_index) == hppp_pkg::REG_SHIFT_X
                              || hppp_pkg::reg_index_t'(cfg_index) == hppp_pkg::REG_SHIFT_Y
                              || hppp_pkg::reg_index_t'(cfg_index) == hppp_pkg::REG_SHIFT_Z
                              || hppp_pkg::reg_index_t'(cfg_index) == hppp_pkg::REG_THREE_D_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x      <= '0;
      shift_y      <= '0;
      shift_z      <= '0;
      blend_weight <= hppp_pkg::WEIGHT_ONE;
      three_d_mode <= 1'b0;
      plain_shift  <= 1'b0;
      rebuild      <= 1'b0;
    end else begin
      rebuild <= shape_write;
      if (cfg_we) begin
        case (hppp_pkg::reg_index_t'(cfg_index))
          hppp_pkg::REG_SHIFT_X:      shift_x      <= $signed(cfg_data);
          hppp_pkg::REG_SHIFT_Y:      shift_y      <= $signed(cfg_data);
          hppp_pkg::REG_SHIFT_Z:      shift_z      <= $signed(cfg_data);
          hppp_pkg::REG_BLEND_WEIGHT: blend_weight <= cfg_data[hppp_pkg::WEIGHT_W-1:0];
          hppp_pkg::REG_THREE_D_MODE: three_d_mode <= cfg_data[0];
          hppp_pkg::REG_PLAIN_SHIFT:  plain_shift  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // z shift only counts in 3D
  assign cfg.t[0]   = shift_x;
  assign cfg.t[1]   = shift_y;
  assign cfg.t[2]   = three_d_mode ? shift_z : '0;
  assign cfg.plain   = plain_shift;
  assign cfg.three_d = three_d_mode;
  assign cfg.weight  = blend_weight;

  assign full   = !front_ready || build_busy || rebuild;
  assign accept = push && !full;
  assign in_v   = {point.coord_z, point.coord_y, point.coord_x};

  hppp_boost #(.FRAC_BITS(FRAC_BITS)) u_boost (
    .clk  (clk),
    .rst  (rst),
    .start(rebuild),
    .t    (cfg.t),
    .busy (build_busy),
    .blk  (blk)
  );

  hppp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (accept),
    .in_v    (in_v),
    .cfg     (cfg),
    .blk     (blk),
    .mid_full(mid_full),
    .ready   (front_ready),
    .mid_push(mid_push),
    .mid_data(mid_wdata)
  );

  hppp_fifo #(.WIDTH($bits(hppp_pkg::vec3_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push),
    .wdata(mid_wdata),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .full (mid_full),
    .empty(mid_empty)
  );

  hppp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_empty(mid_empty),
    .mid_data (mid_rdata),
    .cfg      (cfg),
    .out_full (out_full),
    .mid_pop  (mid_pop),
    .out_push (out_push),
    .out_data (out_wdata)
  );

  hppp_fifo #(.WIDTH($bits(hppp_pkg::result_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(out_wdata),
    .pop  (pop),
    .rdata(result),
    .full (out_full),
    .empty(empty)
  );

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    build_busy |-> full) else $error("item accepted during matrix rebuild");

  a_write_stalls: assert property (@(posedge clk) disable iff (rst)
    shape_write |=> full) else $error("input open right after shape write");

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_full) else $error("mid queue overflow");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full) else $error("result queue overflow");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the hyperboloid translate-and-project block.
`timescale 1ns / 100ps

module tb_top;

  localparam int FB = 24;
  localparam int IW = hppp_pkg::REG_IDX_W;
  localparam int DW = hppp_pkg::CFG_DATA_W;
  localparam longint UNIT = 64'sd1 << FB;
  localparam longint SHIFT_MAX = 167772160;
  localparam longint CLOSE_SQ = (64'sd1 << (2 * FB)) / 1000000;
  localparam logic [IW-1:0] REG_UNUSED = 3'd6;
  localparam logic [IW-1:0] REG_LAST_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 5000;

  logic clk, rst, push, pop, full, empty, cfg_we;
  hppp_pkg::point_t point;
  hppp_pkg::result_t result;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  hyperboloid_point_translate_project DUT (
    .clk(clk), .rst(rst), .push(push), .point(point), .full(full), .empty(empty),
    .pop(pop), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the block's registers and boost matrix
  longint tx, ty, tz, lam_w, mode3d, subtract_mode;
  longint boost[16];

  hppp_pkg::result_t pending_results[$];
  int errors = 0;
  bit quiet = 0;
  int stall_cnt = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint root_floor(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint lift_time(longint a, longint b, longint c);
    bit [63:0] s;
    s = 64'(a * a) + 64'(b * b) + 64'(c * c) + 64'(UNIT * UNIT);
    return clamp32(root_floor(s));
  endfunction

  function automatic longint eff_z();
    return mode3d ? tz : 0;
  endfunction

  function automatic void rebuild_boost();
    longint t[3];
    longint x0, den, v;
    bit [63:0] c2;
    t[0] = tx; t[1] = ty; t[2] = eff_z();
    c2 = 64'(t[0] * t[0]) + 64'(t[1] * t[1]) + 64'(t[2] * t[2]);
    x0 = clamp32(root_floor(c2 + 64'(UNIT * UNIT)));
    den = x0 + UNIT;
    boost[0] = x0;
    for (int r = 1; r < 4; r++) begin
      boost[r] = clamp32(-t[r-1]);
      boost[r*4] = clamp32(-t[r-1]);
      for (int c = 1; c < 4; c++) begin
        v = (r == c) ? UNIT : 0;
        if (c2 > 64'(CLOSE_SQ)) v += (t[r-1] * t[c-1]) / den;
        boost[r*4+c] = clamp32(v);
      end
    end
  endfunction

  function automatic void apply_write(logic [IW-1:0] idx, logic [DW-1:0] d);
    case (idx)
      hppp_pkg::REG_SHIFT_X: begin
        tx = longint'($signed(d[hppp_pkg::SHIFT_W-1:0])); rebuild_boost();
      end
      hppp_pkg::REG_SHIFT_Y: begin
        ty = longint'($signed(d[hppp_pkg::SHIFT_W-1:0])); rebuild_boost();
      end
      hppp_pkg::REG_SHIFT_Z: begin
        tz = longint'($signed(d[hppp_pkg::SHIFT_W-1:0])); rebuild_boost();
      end
      hppp_pkg::REG_BLEND_WEIGHT: lam_w = longint'(d[hppp_pkg::WEIGHT_W-1:0]);
      hppp_pkg::REG_THREE_D_MODE: begin mode3d = d[0]; rebuild_boost(); end
      hppp_pkg::REG_PLAIN_SHIFT: subtract_mode = d[0];
      default: ;
    endcase
  endfunction

  function automatic hppp_pkg::result_t project_point(hppp_pkg::point_t pt);
    longint p[4], y[4], q[4], m[4], t[3];
    longint s, den, w;
    hppp_pkg::result_t res;
    p[1] = pt.coord_x; p[2] = pt.coord_y; p[3] = pt.coord_z;
    p[0] = lift_time(p[1], p[2], p[3]);
    t[0] = tx; t[1] = ty; t[2] = eff_z();
    for (int r = 1; r < 4; r++) begin
      if (subtract_mode != 0) begin
        y[r] = clamp32(p[r] - t[r-1]);
      end else begin
        s = 0;
        for (int c = 0; c < 4; c++) s += (boost[r*4+c] * p[c]) >>> FB;
        y[r] = clamp32(s);
      end
    end
    y[0] = lift_time(y[1], y[2], y[3]);
    den = y[0] + UNIT;
    q[0] = 0;
    for (int r = 1; r < 4; r++) q[r] = (y[r] * UNIT) / den;
    w = 65536 - lam_w;
    for (int r = 0; r < 4; r++) m[r] = clamp32((w * y[r] + lam_w * q[r]) >>> 16);
    res.out_first = m[1][31:0];
    res.out_second = m[2][31:0];
    res.out_third = mode3d ? m[3][31:0] : m[0][31:0];
    return res;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] d);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    apply_write(idx, d);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // push one item; predicts at the accepting edge
  task automatic send_point(hppp_pkg::point_t pt);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    push <= 1;
    point <= pt;
    do @(posedge clk); while (full);
    pending_results.insert(pending_results.size(), project_point(pt));
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      2: return 32'($signed($urandom_range(0, 64 << FB)) - (32 << FB));
      default: return 32'($signed($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_shift();
    case ($urandom_range(0, 5))
      0: return DW'(SHIFT_MAX);
      1: return DW'(-SHIFT_MAX);
      2: return DW'($signed($urandom_range(0, 400)) - 200);
      default: return DW'(longint'($urandom_range(0, 2 * SHIFT_MAX)) - SHIFT_MAX);
    endcase
  endfunction

  // result side: pop with random stall bursts
  initial begin
    pop = 0;
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        @(negedge clk);
        pop <= 0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
      @(negedge clk);
      pop <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report("unexpected item", result.out_first, 32'hx);
      end else begin
        hppp_pkg::result_t want;
        want = pending_results.pop_front();
        if (result.out_first !== want.out_first) report("out_first", result.out_first, want.out_first);
        if (result.out_second !== want.out_second)
          report("out_second", result.out_second, want.out_second);
        if (result.out_third !== want.out_third) report("out_third", result.out_third, want.out_third);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  typedef struct {
    hppp_pkg::point_t pt;
    bit has_want;
    hppp_pkg::result_t want;
  } stim_row_t;

  stim_row_t rows[$];

  initial begin
    hppp_pkg::point_t pt;
    hppp_pkg::result_t pred;
    rst = 1; push = 0; point = '0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    tx = 0; ty = 0; tz = 0; lam_w = 65536; mode3d = 0; subtract_mode = 0;
    rebuild_boost();
    repeat (11) @(negedge clk);
    rst <= 0;

    // origin maps to origin under reset settings
    rows.insert(rows.size(), '{'{32'sd0, 32'sd0, 32'sd0}, 1, '{32'sd0, 32'sd0, 32'sd0}});
    rows.insert(rows.size(), '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 0, '0});
    rows.insert(rows.size(), '{'{32'sh80000000, 32'sh80000000, 32'sh80000000}, 0, '0});
    rows.insert(rows.size(), '{'{32'sh7FFFFFFF, 32'sh80000000, 32'sd0}, 0, '0});
    rows.insert(rows.size(), '{'{32'sh01000000, 32'sd0, 32'sd0}, 0, '0});
    rows.insert(rows.size(), '{'{32'sd0, -32'sh01000000, 32'sh01000000}, 0, '0});
    rows.insert(rows.size(), '{'{32'sd1, -32'sd1, 32'sd1}, 0, '0});
    rows.insert(rows.size(), '{'{32'sh05000000, 32'sh03000000, -32'sh07000000}, 0, '0});
    rows.insert(rows.size(), '{'{32'shFFFFFFFF, 32'sh55555555, 32'shAAAAAAAA}, 0, '0});
    foreach (rows[i]) begin
      send_point(rows[i].pt);
      if (rows[i].has_want) begin
        pred = pending_results[$];
        if (pred.out_first !== rows[i].want.out_first)
          report("table out_first", pred.out_first, rows[i].want.out_first);
        if (pred.out_second !== rows[i].want.out_second)
          report("table out_second", pred.out_second, rows[i].want.out_second);
        if (pred.out_third !== rows[i].want.out_third)
          report("table out_third", pred.out_third, rows[i].want.out_third);
      end
    end
    drain();

    // fixed settings, most of them extreme, then random ones
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          write_reg(hppp_pkg::REG_SHIFT_X, DW'(SHIFT_MAX));
          write_reg(hppp_pkg::REG_SHIFT_Y, DW'(-SHIFT_MAX));
          write_reg(hppp_pkg::REG_SHIFT_Z, DW'(SHIFT_MAX));
          write_reg(hppp_pkg::REG_THREE_D_MODE, DW'(1));
          write_reg(hppp_pkg::REG_BLEND_WEIGHT, DW'(0));
        end
        1: begin
          write_reg(hppp_pkg::REG_BLEND_WEIGHT, DW'(131071));
          write_reg(hppp_pkg::REG_PLAIN_SHIFT, DW'(1));
        end
        2: begin
          write_reg(hppp_pkg::REG_SHIFT_X, DW'(100));
          write_reg(hppp_pkg::REG_SHIFT_Y, DW'(-100));
          write_reg(hppp_pkg::REG_SHIFT_Z, DW'(0));
          write_reg(hppp_pkg::REG_PLAIN_SHIFT, DW'(0));
          write_reg(hppp_pkg::REG_BLEND_WEIGHT, DW'(65536));
          write_reg(REG_UNUSED, '1);
        end
        3: begin
          write_reg(hppp_pkg::REG_THREE_D_MODE, DW'(0));
          write_reg(hppp_pkg::REG_SHIFT_Z, DW'(-SHIFT_MAX));
          write_reg(hppp_pkg::REG_SHIFT_X, DW'(-SHIFT_MAX));
          write_reg(hppp_pkg::REG_BLEND_WEIGHT, DW'(32768));
        end
        default: begin
          write_reg(hppp_pkg::REG_SHIFT_X, rand_shift());
          write_reg(hppp_pkg::REG_SHIFT_Y, rand_shift());
          write_reg(hppp_pkg::REG_SHIFT_Z, rand_shift());
          write_reg(hppp_pkg::REG_BLEND_WEIGHT, DW'($urandom_range(0, 131071)));
          write_reg(hppp_pkg::REG_THREE_D_MODE, DW'($urandom_range(0, 1)));
          write_reg(hppp_pkg::REG_PLAIN_SHIFT, DW'($urandom_range(0, 1)));
          if ($urandom_range(0, 3) == 0) write_reg(REG_LAST_UNUSED, DW'($urandom()));
        end
      endcase
      if (ph == 11) quiet = 1;
      repeat (135) begin
        pt.coord_x = rand_coord();
        pt.coord_y = rand_coord();
        pt.coord_z = rand_coord();
        send_point(pt);
      end
      drain();
    end

    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* hyperboloid_point_translate_project.f */
hw/rtl/hppp_pkg.sv
hw/rtl/hppp_fifo.sv
hw/rtl/hppp_lift.sv
hw/rtl/hppp_boost.sv
hw/rtl/hppp_front.sv
hw/rtl/hppp_back.sv
hw/rtl/hyperboloid_point_translate_project.sv
tb/tb_top.sv
